// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the allocator. Every check is sampled on aclk and is
// switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NFLA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NFLA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/nfla_pkg.sv =====
package nfla_pkg;

    localparam int ENTRIES_DEF   = 128;
    localparam int WORD_BITS_DEF = 64;
    localparam int CORES_DEF     = 8;

    typedef enum logic [1:0] {
        FUNC_REQUEST  = 2'd0,
        FUNC_RESPONSE = 2'd1,
        FUNC_NOTIFY   = 2'd2,
        FUNC_ACK      = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STAT_ALLOCATED = 3'd0,
        STAT_FREED     = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_BAD_CORE  = 3'd3,
        STAT_NOTHING   = 3'd4
    } status_t;

    typedef struct packed {
        func_t      func;
        logic [3:0] core;
    } in_t;

    typedef struct packed {
        status_t     status;
        logic [6:0]  entry_index;
        logic [31:0] msg_number;
    } out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CUR_RD,
        ST_FREE_WR,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

// ===== hw/rtl/next_fit_log_slot_allocator.sv =====
// A bad core or an empty free is answered from idle; a free reads the slot's entry, then
// clears its busy bit; an allocation scans the busy map from the start word, one busy
// word a cycle. A result goes via a result register to the output register; the next
// beat is taken only after that. After reset a clearing pass zeroes the busy map; no
// beat is taken then. Reset is synchronous and active low on aresetn.
module next_fit_log_slot_allocator #(
    parameter int ENTRIES   = nfla_pkg::ENTRIES_DEF,
    parameter int WORD_BITS = nfla_pkg::WORD_BITS_DEF,
    parameter int CORES     = nfla_pkg::CORES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  nfla_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output nfla_pkg::out_t  m_data
);

`include "assert_macros.svh"

    // Geometry of the busy map. The last word may be partly used.
    localparam int WORDS     = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int LAST_BITS = ENTRIES - (WORDS - 1) * WORD_BITS;
    localparam int WA        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BA        = $clog2(WORD_BITS);
    localparam int PW        = WA + BA;
    // One slot per core plus the shared notification slot.
    localparam int SLOTS     = CORES + 1;
    localparam int SA        = $clog2(SLOTS);
    // The search visits the start word twice: once from the start bit up and,
    // at the very end, once below it.
    localparam int KW        = $clog2(WORDS + 1);

    nfla_pkg::state_t state_reg, state_next;
    logic [SA-1:0]    slot_reg, slot_next;
    logic [WA-1:0]    last_word_reg, last_word_next;
    logic [BA-1:0]    last_bit_reg, last_bit_next;
    logic             never_reg, never_next;
    logic [31:0]      msg_reg, msg_next;
    logic [SLOTS-1:0] cur_valid_reg, cur_valid_next;
    logic [KW-1:0]    step_reg, step_next;
    logic [WA-1:0]    word_reg, word_next;
    logic [BA-1:0]    start_bit_reg, start_bit_next;
    logic [BA-1:0]    free_bit_reg, free_bit_next;
    logic [WA-1:0]    clr_reg, clr_next;
    nfla_pkg::out_t   res_reg, res_next;
    nfla_pkg::out_t   m_data_reg, m_data_next;
    logic             m_valid_reg, m_valid_next;

    // Memory ports.
    logic                 busy_we;
    logic [WA-1:0]        busy_waddr;
    logic [WORD_BITS-1:0] busy_wdata;
    logic [WA-1:0]        busy_raddr;
    logic [WORD_BITS-1:0] busy_rdata;
    logic                 cur_we;
    logic [SA-1:0]        cur_raddr;
    logic [PW-1:0]        cur_wdata;
    logic [PW-1:0]        cur_rdata;

    // Search helpers.
    logic          found;
    logic [BA-1:0] found_bit;
    logic          tail_word;
    logic [WA-1:0] word_succ;
    logic          last_tail;
    logic [BA-1:0] last_lim;
    logic [WA-1:0] start_word;
    logic [BA-1:0] start_bit;
    logic          bad_core;
    logic [SA-1:0] slot_in;
    logic [PW-1:0] find_pos;
    logic [PW-1:0] free_pos;

    // The busy map: one word per row, with a registered read port.
    nfla_ram #(
        .DEPTH (WORDS),
        .WIDTH (WORD_BITS)
    ) u_busy_ram (
        .aclk  (aclk),
        .we    (busy_we),
        .waddr (busy_waddr),
        .wdata (busy_wdata),
        .raddr (busy_raddr),
        .rdata (busy_rdata)
    );

    // Current entry of each slot, kept as word and bit. An entry is only ever
    // read while its valid bit is set, so it needs no clearing.
    nfla_ram #(
        .DEPTH (SLOTS),
        .WIDTH (PW)
    ) u_cur_ram (
        .aclk  (aclk),
        .we    (cur_we),
        .waddr (slot_reg),
        .wdata (cur_wdata),
        .raddr (cur_raddr),
        .rdata (cur_rdata)
    );

    nfla_find #(
        .WORD_BITS (WORD_BITS),
        .LAST_BITS (LAST_BITS)
    ) u_find (
        .busy_word  (busy_rdata),
        .start_bit  (start_bit_reg),
        .first_step (step_reg == KW'(0)),
        .final_step (step_reg == KW'(WORDS)),
        .tail_word  (tail_word),
        .found      (found),
        .found_bit  (found_bit)
    );

    assign tail_word = (word_reg == WA'(WORDS - 1));
    assign word_succ = tail_word ? '0 : word_reg + WA'(1);

    // The next-fit search starts just after the last allocated entry and wraps.
    // Before the first allocation it starts at entry zero.
    assign last_tail = (last_word_reg == WA'(WORDS - 1));
    assign last_lim  = last_tail ? BA'(LAST_BITS - 1) : BA'(WORD_BITS - 1);

    always_comb begin
        if (never_reg) begin
            start_word = '0;
            start_bit  = '0;
        end else if (last_bit_reg == last_lim) begin
            start_word = last_tail ? '0 : last_word_reg + WA'(1);
            start_bit  = '0;
        end else begin
            start_word = last_word_reg;
            start_bit  = last_bit_reg + BA'(1);
        end
    end

    // An acknowledge ignores the core field; the other functions check it.
    assign bad_core = (s_data.func != nfla_pkg::FUNC_ACK) && (s_data.core >= 4'(CORES));
    assign slot_in  = ((s_data.func == nfla_pkg::FUNC_REQUEST)
                       || (s_data.func == nfla_pkg::FUNC_RESPONSE))
                      ? SA'(s_data.core) : SA'(CORES);

    // Entry numbers are rebuilt from word and bit; the multiply is by a constant.
    assign find_pos = PW'(word_reg) * PW'(WORD_BITS) + PW'(found_bit);
    assign free_pos = PW'(word_reg) * PW'(WORD_BITS) + PW'(free_bit_reg);

    assign cur_wdata = {word_reg, found_bit};

    always_comb begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        last_word_next = last_word_reg;
        last_bit_next  = last_bit_reg;
        never_next     = never_reg;
        msg_next       = msg_reg;
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        word_next      = word_reg;
        start_bit_next = start_bit_reg;
        free_bit_next  = free_bit_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        busy_we        = 1'b0;
        busy_waddr     = word_reg;
        busy_wdata     = '0;
        busy_raddr     = word_reg;
        cur_we         = 1'b0;
        cur_raddr      = slot_in;
        s_ready        = 1'b0;

        case (state_reg)
            nfla_pkg::ST_CLEAR: begin
                // Mark every entry free, one word a cycle.
                busy_we    = 1'b1;
                busy_waddr = clr_reg;
                busy_wdata = '0;
                if (clr_reg == WA'(WORDS - 1)) begin
                    state_next = nfla_pkg::ST_IDLE;
                end else begin
                    clr_next = clr_reg + WA'(1);
                end
            end

            nfla_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    slot_next = slot_in;
                    if (bad_core) begin
                        res_next   = '{status: nfla_pkg::STAT_BAD_CORE,
                                       entry_index: '0, msg_number: '0};
                        state_next = nfla_pkg::ST_EMIT;
                    end else if ((s_data.func == nfla_pkg::FUNC_REQUEST)
                                 || (s_data.func == nfla_pkg::FUNC_NOTIFY)) begin
                        // Fetch the start word; the scan looks at it next cycle.
                        busy_raddr     = start_word;
                        word_next      = start_word;
                        start_bit_next = start_bit;
                        step_next      = '0;
                        state_next     = nfla_pkg::ST_SCAN;
                    end else if (!cur_valid_reg[slot_in]) begin
                        res_next   = '{status: nfla_pkg::STAT_NOTHING,
                                       entry_index: '0, msg_number: '0};
                        state_next = nfla_pkg::ST_EMIT;
                    end else begin
                        // Fetch the slot's current entry.
                        cur_raddr  = slot_in;
                        state_next = nfla_pkg::ST_CUR_RD;
                    end
                end
            end

            nfla_pkg::ST_CUR_RD: begin
                busy_raddr    = cur_rdata[PW-1:BA];
                word_next     = cur_rdata[PW-1:BA];
                free_bit_next = cur_rdata[BA-1:0];
                state_next    = nfla_pkg::ST_FREE_WR;
            end

            nfla_pkg::ST_FREE_WR: begin
                busy_we    = 1'b1;
                busy_waddr = word_reg;
                busy_wdata = busy_rdata & ~(WORD_BITS'(1) << free_bit_reg);
                cur_valid_next[slot_reg] = 1'b0;
                res_next   = '{status: nfla_pkg::STAT_FREED,
                               entry_index: 7'(free_pos), msg_number: '0};
                state_next = nfla_pkg::ST_EMIT;
            end

            nfla_pkg::ST_SCAN: begin
                if (found) begin
                    busy_we        = 1'b1;
                    busy_waddr     = word_reg;
                    busy_wdata     = busy_rdata | (WORD_BITS'(1) << found_bit);
                    cur_we         = 1'b1;
                    cur_valid_next[slot_reg] = 1'b1;
                    last_word_next = word_reg;
                    last_bit_next  = found_bit;
                    never_next     = 1'b0;
                    msg_next       = msg_reg + 32'd1;
                    res_next       = '{status: nfla_pkg::STAT_ALLOCATED,
                                       entry_index: 7'(find_pos), msg_number: msg_reg};
                    state_next     = nfla_pkg::ST_EMIT;
                end else if (step_reg == KW'(WORDS)) begin
                    // Every entry was looked at: the log is full.
                    cur_valid_next[slot_reg] = 1'b0;
                    res_next   = '{status: nfla_pkg::STAT_FULL,
                                   entry_index: '0, msg_number: '0};
                    state_next = nfla_pkg::ST_EMIT;
                end else begin
                    busy_raddr = word_succ;
                    word_next  = word_succ;
                    step_next  = step_reg + KW'(1);
                end
            end

            nfla_pkg::ST_EMIT: begin
                // Wait for the output register to drain, then hand the result over.
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = nfla_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = nfla_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= nfla_pkg::ST_CLEAR;
            clr_reg       <= '0;
            last_word_reg <= '0;
            last_bit_reg  <= '0;
            never_reg     <= 1'b1;
            msg_reg       <= '0;
            cur_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            last_word_reg <= last_word_next;
            last_bit_reg  <= last_bit_next;
            never_reg     <= never_next;
            msg_reg       <= msg_next;
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg      <= slot_next;
        step_reg      <= step_next;
        word_reg      <= word_next;
        start_bit_reg <= start_bit_next;
        free_bit_reg  <= free_bit_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Every accepted beat moves the controller out of idle.
    `NFLA_ASSERT_NEXT(a_accept_leaves_idle, s_valid && s_ready,
                      state_reg != nfla_pkg::ST_IDLE)
    // The scan never runs past its final visit of the start word.
    `NFLA_ASSERT_SAME(a_step_bound, state_reg == nfla_pkg::ST_SCAN, step_reg <= KW'(WORDS))
    // A grant advances the message number by exactly one.
    `NFLA_ASSERT_NEXT(a_msg_advance, state_reg == nfla_pkg::ST_SCAN && found,
                      msg_reg == $past(msg_reg) + 32'd1)
    // A pending result waits while the output register is still occupied.
    `NFLA_ASSERT_NEXT(a_emit_hold, state_reg == nfla_pkg::ST_EMIT && m_valid_reg && !m_ready,
                      state_reg == nfla_pkg::ST_EMIT)

endmodule

// ===== hw/rtl/nfla_ram.sv =====
module nfla_ram #(
    parameter int DEPTH = nfla_pkg::CORES_DEF + 1,
    parameter int WIDTH = nfla_pkg::WORD_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/nfla_find.sv =====
module nfla_find #(
    parameter int WORD_BITS = nfla_pkg::WORD_BITS_DEF,
    parameter int LAST_BITS = nfla_pkg::WORD_BITS_DEF
) (
    input  logic [WORD_BITS-1:0]         busy_word,
    input  logic [$clog2(WORD_BITS)-1:0] start_bit,
    input  logic                         first_step,
    input  logic                         final_step,
    input  logic                         tail_word,
    output logic                         found,
    output logic [$clog2(WORD_BITS)-1:0] found_bit
);

    localparam int BA = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] cand;

    // A bit is a candidate when it is free, exists in the map and lies in the
    // part of the word that this step of the wrap-around search covers.
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            cand[i] = !busy_word[i]
                && (!tail_word || (i < LAST_BITS))
                && (!first_step || (BA'(i) >= start_bit))
                && (!final_step || (BA'(i) < start_bit));
        end
    end

    always_comb begin
        found     = |cand;
        found_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                found_bit = BA'(i);
            end
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int ENTRY_COUNT = nfla_pkg::ENTRIES_DEF;
    localparam int CORE_COUNT  = nfla_pkg::CORES_DEF;
    // The notification owner sits in the slot just past the last core.
    localparam int NOTIFY_SLOT = CORE_COUNT;

    // The idling pattern changes with the number of input beats taken so far.
    localparam int PATTERN_SWAP_AT = 580;
    localparam int PATTERN_OFF_AT  = 1140;

    // Once this many results have arrived, the receiver stops for a long stretch.
    localparam int HOLD_AT     = 1450;
    localparam int HOLD_CYCLES = 300;

    // Cycles allowed after the last result, and the overall watchdog budget.
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 200000;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    nfla_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    nfla_pkg::out_t m_data;

    next_fit_log_slot_allocator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Allocator shadow state. It is advanced once per accepted input beat,
    // in the same order the block sees them.
    // ------------------------------------------------------------------
    logic [ENTRY_COUNT-1:0] busy_bits;
    int                     last_grant;
    bit                     first_grant_pending;
    logic [31:0]            next_msg;
    int                     slot_entry [CORE_COUNT+1];
    bit                     slot_valid [CORE_COUNT+1];

    // Results the block still owes us, oldest first.
    nfla_pkg::out_t awaited[$];
    // Beats waiting to be offered to the block.
    nfla_pkg::in_t  pending[$];

    int tally [5];
    int errors       = 0;
    int beats_in     = 0;
    int results_seen = 0;
    int cycles       = 0;

    // Stimulus side bookkeeping: which slots the generator believes hold an entry.
    // It only steers the stimulus toward sensible sequences, so it may drift.
    bit gen_holds [CORE_COUNT+1];

    // Receiver hold-off counter and its one-shot flag.
    int hold_left = 0;
    bit hold_done = 1'b0;

    nfla_pkg::out_t want;

    // Works out what the block must answer to one beat and records it.
    task automatic predict_outcome(input nfla_pkg::in_t beat);
        nfla_pkg::out_t res;
        int             slot;
        int             pos;
        bit             found;
        res   = '0;
        pos   = 0;
        found = 1'b0;
        if (beat.func != nfla_pkg::FUNC_ACK && beat.core >= CORE_COUNT) begin
            // A bad core leaves the whole state alone.
            res.status = nfla_pkg::STAT_BAD_CORE;
        end else begin
            slot = (beat.func == nfla_pkg::FUNC_REQUEST
                    || beat.func == nfla_pkg::FUNC_RESPONSE) ?
                   int'(beat.core) : NOTIFY_SLOT;
            if (beat.func == nfla_pkg::FUNC_REQUEST
                || beat.func == nfla_pkg::FUNC_NOTIFY) begin
                // Next-fit: start just after the last grant, wrap, and look at
                // the last granted entry itself only at the very end.
                if (first_grant_pending) begin
                    found = 1'b1;
                end else begin
                    for (int i = 1; i <= ENTRY_COUNT && !found; i++) begin
                        pos   = (last_grant + i) % ENTRY_COUNT;
                        found = !busy_bits[pos];
                    end
                end
                if (!found) begin
                    // A full log drops the requester's pointer; the counter holds.
                    slot_valid[slot] = 1'b0;
                    res.status       = nfla_pkg::STAT_FULL;
                end else begin
                    busy_bits[pos]      = 1'b1;
                    res.status          = nfla_pkg::STAT_ALLOCATED;
                    res.entry_index     = 7'(pos);
                    res.msg_number      = next_msg;
                    last_grant          = pos;
                    first_grant_pending = 1'b0;
                    next_msg            = next_msg + 32'd1;
                    // An older entry still held by this slot simply stays busy.
                    slot_entry[slot]    = pos;
                    slot_valid[slot]    = 1'b1;
                end
            end else if (!slot_valid[slot]) begin
                res.status = nfla_pkg::STAT_NOTHING;
            end else begin
                busy_bits[slot_entry[slot]] = 1'b0;
                slot_valid[slot]            = 1'b0;
                res.status                  = nfla_pkg::STAT_FREED;
                res.entry_index             = 7'(slot_entry[slot]);
            end
        end
        tally[res.status] = tally[res.status] + 1;
        awaited.push_back(res);
    endtask

    function automatic void queue_beat(input nfla_pkg::func_t f, input int core);
        nfla_pkg::in_t beat;
        beat.func = f;
        beat.core = 4'(core);
        pending.push_back(beat);
    endfunction

    // Allocation for a slot: a request from a core, or a notification from any valid core.
    function automatic void queue_alloc(input int slot);
        if (slot == NOTIFY_SLOT) begin
            queue_beat(nfla_pkg::FUNC_NOTIFY, $urandom_range(CORE_COUNT - 1, 0));
        end else begin
            queue_beat(nfla_pkg::FUNC_REQUEST, slot);
        end
        gen_holds[slot] = 1'b1;
    endfunction

    // Free for a slot. An acknowledge ignores the core, so any value goes.
    function automatic void queue_free(input int slot);
        if (slot == NOTIFY_SLOT) begin
            queue_beat(nfla_pkg::FUNC_ACK, $urandom_range(15, 0));
        end else begin
            queue_beat(nfla_pkg::FUNC_RESPONSE, slot);
        end
        gen_holds[slot] = 1'b0;
    endfunction

    // Mostly allocate/free pairs with random owners. leak_pct is the chance that a
    // slot already holding an entry allocates again and so strands the old entry.
    task automatic add_mixed(input int count, input int leak_pct);
        int dice;
        int slot;
        repeat (count) begin
            dice = $urandom_range(99, 0);
            slot = $urandom_range(CORE_COUNT, 0);
            if (dice < 6) begin
                queue_beat(nfla_pkg::func_t'($urandom_range(2, 0)),
                           $urandom_range(15, CORE_COUNT));
            end else if (dice < 10) begin
                queue_beat(nfla_pkg::func_t'($urandom_range(3, 0)), $urandom_range(15, 0));
            end else if (gen_holds[slot] && $urandom_range(99, 0) >= leak_pct) begin
                queue_free(slot);
            end else if (!gen_holds[slot] && $urandom_range(99, 0) < 5) begin
                queue_free(slot);
            end else begin
                queue_alloc(slot);
            end
        end
    endtask

    function automatic void check_field(input string label, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, exp_val,
                     act_val);
            errors = errors + 1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver. A beat is taken when valid and ready are both high at an edge;
    // the next beat (or an idle cycle) is chosen only after the current one has
    // gone, so valid is never pulled back while a beat is on offer.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                predict_outcome(s_data);
                beats_in <= beats_in + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending.size() != 0 &&
                    $urandom_range(99, 0) >= (beats_in < PATTERN_SWAP_AT ? 29 :
                                              beats_in < PATTERN_OFF_AT ? 64 : 0)) begin
                    s_data  <= pending.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Every result beat is matched against the oldest expectation.
    // The receiver idles at random until PATTERN_OFF_AT input beats have been taken, and
    // during the long hold-off it does not take anything at all.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got status %0d",
                             $time, m_data.status);
                    errors = errors + 1;
                end else begin
                    want = awaited.pop_front();
                    check_field("status", 32'(want.status), 32'(m_data.status));
                    check_field("entry_index", 32'(want.entry_index), 32'(m_data.entry_index));
                    check_field("msg_number", want.msg_number, m_data.msg_number);
                end
                results_seen <= results_seen + 1;
            end
            m_ready <= (hold_left == 0) &&
                       ($urandom_range(99, 0) >= (beats_in < PATTERN_SWAP_AT ? 64 :
                                                  beats_in < PATTERN_OFF_AT ? 29 : 0));
        end
    end

    // Long receiver hold-off. The sender keeps pushing meanwhile, so the block's
    // output stays occupied and it has to push back on its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Watchdog: a stuck handshake ends the run here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats pending and %0d results outstanding",
                     $time, pending.size(), awaited.size());
            $display("[next_fit_log_slot_allocator] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        busy_bits           = '0;
        last_grant          = 0;
        first_grant_pending = 1'b1;
        next_msg            = '0;
        for (int s = 0; s <= CORE_COUNT; s++) begin
            slot_entry[s] = 0;
            slot_valid[s] = 1'b0;
            gen_holds[s]  = 1'b0;
        end
        for (int k = 0; k < 5; k++) begin
            tally[k] = 0;
        end

        // Directed opening. Frees before anything was granted find nothing.
        queue_beat(nfla_pkg::FUNC_ACK, 15);
        queue_beat(nfla_pkg::FUNC_RESPONSE, 0);
        // The first grant after reset is entry 0; then next-fit moves on.
        queue_beat(nfla_pkg::FUNC_REQUEST, 0);
        queue_beat(nfla_pkg::FUNC_REQUEST, CORE_COUNT - 1);
        queue_beat(nfla_pkg::FUNC_NOTIFY, 3);
        // Cores past the last one are rejected for all but an acknowledge.
        queue_beat(nfla_pkg::FUNC_REQUEST, CORE_COUNT);
        queue_beat(nfla_pkg::FUNC_RESPONSE, 15);
        queue_beat(nfla_pkg::FUNC_NOTIFY, 12);
        // Freeing entry 0 must not pull the next grant back to it.
        queue_beat(nfla_pkg::FUNC_RESPONSE, 0);
        queue_beat(nfla_pkg::FUNC_REQUEST, 0);
        // A second request with a pointer still live strands the earlier entry.
        queue_beat(nfla_pkg::FUNC_REQUEST, 0);
        queue_beat(nfla_pkg::FUNC_ACK, 9);
        queue_beat(nfla_pkg::FUNC_ACK, 0);
        queue_beat(nfla_pkg::FUNC_RESPONSE, CORE_COUNT - 1);
        queue_beat(nfla_pkg::FUNC_RESPONSE, CORE_COUNT - 1);
        queue_beat(nfla_pkg::FUNC_REQUEST, 5);
        queue_beat(nfla_pkg::FUNC_NOTIFY, 0);
        queue_beat(nfla_pkg::FUNC_RESPONSE, 5);
        queue_beat(nfla_pkg::FUNC_ACK, 6);
        queue_beat(nfla_pkg::FUNC_RESPONSE, 0);

        // Random traffic: two long stretches of well-formed pairs, a burst of
        // stranded grants that fills the log, then recycling of a full log.
        add_mixed(560, 3);
        add_mixed(560, 3);
        add_mixed(160, 100);
        add_mixed(450, 3);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_valid || awaited.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (awaited.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, awaited.size());
            errors = errors + 1;
        end

        $display("Covered %0d beats: %0d grants, %0d frees, %0d log-full refusals,",
                 beats_in, tally[nfla_pkg::STAT_ALLOCATED], tally[nfla_pkg::STAT_FREED],
                 tally[nfla_pkg::STAT_FULL]);
        $display("%0d rejected cores and %0d empty frees; %0d mismatches.",
                 tally[nfla_pkg::STAT_BAD_CORE], tally[nfla_pkg::STAT_NOTHING], errors);
        if (errors == 0) begin
            $display("[next_fit_log_slot_allocator] OK");
        end else begin
            $display("[next_fit_log_slot_allocator] ERROR");
        end
        $finish;
    end

endmodule
